// File: rtl/fle_pkg.sv
// Package for the filtered line editor core.
// Holds byte codes, register addresses, reset values and the character class check.
// No dependencies.
`default_nettype none

package fle_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 32;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    localparam logic [1:0] MODE_DIGITS  = 2'd0;
    localparam logic [1:0] MODE_LETTERS = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;

    localparam logic [1:0] RESET_MODE       = MODE_TEXT;
    localparam logic [5:0] RESET_MAX_LENGTH = 6'd32;

    localparam logic REG_CHAR_CLASS_MODE = 1'b0;
    localparam logic REG_MAX_LENGTH      = 1'b1;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic class_allowed(input logic [1:0] mode, input logic [7:0] c);
        logic ok;
        case (mode)
            MODE_DIGITS:  ok = is_digit(c);
            MODE_LETTERS: ok = is_letter(c);
            default:      ok = is_letter(c) || is_digit(c) || (c == CHAR_SPACE) ||
                               (c == CHAR_BANG) || (c == CHAR_DOT) ||
                               (c == CHAR_MINUS) || (c == CHAR_PLUS);
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: rtl/filtered_line_editor_core.sv
// Filtered terminal line editor: top level with line buffer, sequencer and APB registers.
// Depends on fle_pkg.
`default_nettype none

// One received byte is taken per request while in_ready is high; in_ready drops until every
// result of that byte has been loaded into the output register, one result per cycle that the
// output side is free. A stored character gives its echo, a backspace BS, space, BS, and a
// completed line of n characters CR, LF, n bytes walked out of the line buffer through its
// registered read port, and a terminator. Bytes that cause no result leave in_ready high.
// The user is to write char_class_mode and max_length over the APB port only while the block
// is idle; the block does not enforce this. The line buffer needs no clearing pass after reset.
module filtered_line_editor_core #(
    parameter int BUFFER_DEPTH = fle_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [7:0]  out_byte,
    output logic             is_echo,
    output logic             last
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = ((FW > 6) ? FW : 6) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ECHO = 3'd1;
    localparam logic [2:0] S_BS1  = 3'd2;
    localparam logic [2:0] S_BS2  = 3'd3;
    localparam logic [2:0] S_BS3  = 3'd4;
    localparam logic [2:0] S_CR   = 3'd5;
    localparam logic [2:0] S_LF   = 3'd6;
    localparam logic [2:0] S_LINE = 3'd7;
    localparam logic [2:0] S_TERM_CODE = 3'd0;

    logic [1:0]    mode_reg;
    logic [5:0]    max_length_reg;
    logic [2:0]    state_reg, state_next;
    logic          term_reg, term_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] k_reg, k_next;
    logic [7:0]    char_reg, char_next;
    logic          fin_reg, fin_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          is_echo_reg, is_echo_next;
    logic          last_reg, last_next;
    logic [7:0]    line_store [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;

    logic          accept;
    logic          cfg_write;
    logic          can_emit;
    logic          room;
    logic          store_en;
    logic [CW-1:0] ml_ext;
    logic [CW-1:0] limit;
    logic [FW-1:0] fill_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign accept    = in_valid && in_ready;
    assign can_emit  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && !term_reg;
    assign room      = fill_reg < FW'(BUFFER_DEPTH);
    assign fill_inc  = room ? (fill_reg + FW'(1)) : fill_reg;
    assign ml_ext    = CW'(max_length_reg);

    always_comb
    begin
        if (ml_ext < CW'(2))
            limit = CW'(2);
        else if (ml_ext > CW'(BUFFER_DEPTH))
            limit = CW'(BUFFER_DEPTH);
        else
            limit = ml_ext;
    end

    always_comb
    begin
        prdata = 32'd0;
        case (paddr[2])
            fle_pkg::REG_CHAR_CLASS_MODE: prdata[1:0] = mode_reg;
            fle_pkg::REG_MAX_LENGTH:      prdata[5:0] = max_length_reg;
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= fle_pkg::RESET_MODE;
            max_length_reg <= fle_pkg::RESET_MAX_LENGTH;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                fle_pkg::REG_CHAR_CLASS_MODE: mode_reg <= pwdata[1:0];
                fle_pkg::REG_MAX_LENGTH:      max_length_reg <= pwdata[5:0];
                default:                      mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        char_next      = char_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        is_echo_next   = is_echo_reg;
        last_next      = last_reg;
        store_en       = 1'b0;

        if (term_reg)
        begin
            // terminator of a completed line
            if (can_emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = fle_pkg::CHAR_NUL;
                is_echo_next   = 1'b0;
                last_next      = 1'b1;
                fill_next      = '0;
                term_next      = 1'b0;
                state_next     = S_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if ((rx_byte == fle_pkg::CHAR_CR) || (rx_byte == fle_pkg::CHAR_LF))
                        begin
                            k_next     = '0;
                            state_next = S_CR;
                        end
                        else if ((rx_byte == fle_pkg::CHAR_BS) ||
                                 (rx_byte == fle_pkg::CHAR_DEL))
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next  = fill_reg - FW'(1);
                                state_next = S_BS1;
                            end
                        end
                        else if (fle_pkg::class_allowed(mode_reg, rx_byte))
                        begin
                            store_en   = room;
                            fill_next  = fill_inc;
                            char_next  = rx_byte;
                            fin_next   = (CW'(fill_inc) + CW'(1)) >= limit;
                            k_next     = '0;
                            state_next = S_ECHO;
                        end
                    end
                end
                S_ECHO:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = char_reg;
                        is_echo_next   = 1'b1;
                        last_next      = !fin_reg;
                        state_next     = fin_reg ? S_CR : S_IDLE;
                    end
                end
                S_BS1:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = fle_pkg::CHAR_BS;
                        is_echo_next   = 1'b1;
                        last_next      = 1'b0;
                        state_next     = S_BS2;
                    end
                end
                S_BS2:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = fle_pkg::CHAR_SPACE;
                        is_echo_next   = 1'b1;
                        last_next      = 1'b0;
                        state_next     = S_BS3;
                    end
                end
                S_BS3:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = fle_pkg::CHAR_BS;
                        is_echo_next   = 1'b1;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                S_CR:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = fle_pkg::CHAR_CR;
                        is_echo_next   = 1'b1;
                        last_next      = 1'b0;
                        state_next     = S_LF;
                    end
                end
                S_LF:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = fle_pkg::CHAR_LF;
                        is_echo_next   = 1'b1;
                        last_next      = 1'b0;
                        if (fill_reg == '0)
                        begin
                            term_next  = 1'b1;
                            state_next = S_TERM_CODE;
                        end
                        else
                            state_next = S_LINE;
                    end
                end
                S_LINE:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = rd_data_reg;
                        is_echo_next   = 1'b0;
                        last_next      = 1'b0;
                        if ((FW'(k_reg) + FW'(1)) >= fill_reg)
                        begin
                            term_next  = 1'b1;
                            state_next = S_TERM_CODE;
                        end
                        else
                            k_next = k_reg + AW'(1);
                    end
                end
                default:
                    state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            term_reg      <= 1'b0;
            fill_reg      <= '0;
            k_reg         <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        out_byte_reg <= out_byte_next;
        is_echo_reg  <= is_echo_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
            line_store[fill_reg[AW-1:0]] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= line_store[k_next];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_echo   = is_echo_reg;
    assign last      = last_reg;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FW'(BUFFER_DEPTH))
        else $error("fill index reached buffer depth");

    a_line_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE) && !term_reg |-> FW'(k_reg) < fill_reg)
        else $error("line walk past stored characters");

    a_end_of_line: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((rx_byte == fle_pkg::CHAR_CR) || (rx_byte == fle_pkg::CHAR_LF))
        |=> (state_reg == S_CR) && !in_ready)
        else $error("line end request did not start CR LF sequence");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        term_reg && can_emit |=> (fill_reg == '0) && out_valid_reg && last_reg)
        else $error("terminator did not close the line");

endmodule

`default_nettype wire

// File: sim/filtered_line_editor_checker.sv
`timescale 1ns / 1ps
// Result checker for the filtered line editor core: tracks register writes, predicts
// echo and line bytes for every accepted request and compares them with the output stream.
// Depends on fle_pkg.
module filtered_line_editor_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  out_byte,
    input  wire logic        is_echo,
    input  wire logic        last,
    output int               mismatch_count,
    output int               results_outstanding,
    output int               edited_items
);

    localparam int LINE_DEPTH = fle_pkg::DEFAULT_BUFFER_DEPTH;
    localparam logic [2:0] MODE_ADDR   = {fle_pkg::REG_CHAR_CLASS_MODE, 2'b00};
    localparam logic [2:0] LENGTH_ADDR = {fle_pkg::REG_MAX_LENGTH, 2'b00};

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_echo;
        logic       last;
    } editor_result_t;

    editor_result_t expected_bytes[$];
    logic [7:0]     line_chars[LINE_DEPTH];
    int             line_fill;
    int             step_results;
    logic [1:0]     class_mode;
    logic [5:0]     line_max;

    function automatic logic class_accepts(input logic [1:0] mode, input logic [7:0] c);
        logic digit;
        logic letter;
        logic punct;
        digit  = (c >= 8'h30) && (c <= 8'h39);
        letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
        punct  = (c == fle_pkg::CHAR_SPACE) || (c == fle_pkg::CHAR_BANG) ||
                 (c == fle_pkg::CHAR_DOT) || (c == fle_pkg::CHAR_MINUS) ||
                 (c == fle_pkg::CHAR_PLUS);
        case (mode)
            fle_pkg::MODE_DIGITS:  return digit;
            fle_pkg::MODE_LETTERS: return letter;
            default:               return letter || digit || punct;
        endcase
    endfunction

    function automatic int line_limit(input logic [5:0] max_len);
        if (max_len < 2)
            return 2;
        if (max_len > LINE_DEPTH)
            return LINE_DEPTH;
        return max_len;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic echo);
        editor_result_t r;
        r.out_byte = b;
        r.is_echo  = echo;
        r.last     = 1'b0;
        expected_bytes.push_back(r);
        step_results++;
    endtask

    task automatic close_line();
        push_byte(fle_pkg::CHAR_CR, 1'b1);
        push_byte(fle_pkg::CHAR_LF, 1'b1);
        for (int k = 0; k < line_fill; k++)
            push_byte(line_chars[k], 1'b0);
        push_byte(fle_pkg::CHAR_NUL, 1'b0);
        line_fill = 0;
    endtask

    task automatic edit_line(input logic [7:0] c);
        editor_result_t r;
        step_results = 0;
        if (c == fle_pkg::CHAR_CR || c == fle_pkg::CHAR_LF)
        begin
            close_line();
        end
        else if (c == fle_pkg::CHAR_BS || c == fle_pkg::CHAR_DEL)
        begin
            if (line_fill > 0)
            begin
                line_fill--;
                push_byte(fle_pkg::CHAR_BS, 1'b1);
                push_byte(fle_pkg::CHAR_SPACE, 1'b1);
                push_byte(fle_pkg::CHAR_BS, 1'b1);
            end
        end
        else if (class_accepts(class_mode, c))
        begin
            if (line_fill < LINE_DEPTH)
            begin
                line_chars[line_fill] = c;
                line_fill++;
            end
            push_byte(c, 1'b1);
            if (line_fill + 1 >= line_limit(line_max))
                close_line();
        end
        if (step_results > 0)
        begin
            r = expected_bytes.pop_back();
            r.last = 1'b1;
            expected_bytes.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        editor_result_t want;
        int bad;
        if (!rst_n)
        begin
            expected_bytes.delete();
            line_fill = 0;
            class_mode = fle_pkg::RESET_MODE;
            line_max = fle_pkg::RESET_MAX_LENGTH;
            mismatch_count <= 0;
            results_outstanding <= 0;
            edited_items <= 0;
        end
        else
        begin
            bad = 0;
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result out_byte %02h is_echo %0b last %0b",
                             $time, out_byte, is_echo, last);
                    bad++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, out_byte);
                        bad++;
                    end
                    if (is_echo !== want.is_echo)
                    begin
                        $display("%0t: is_echo expected %0b actual %0b",
                                 $time, want.is_echo, is_echo);
                        bad++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                        bad++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == MODE_ADDR)
                    class_mode = pwdata[1:0];
                else if (paddr == LENGTH_ADDR)
                    line_max = pwdata[5:0];
            end
            if (in_valid && in_ready)
            begin
                edit_line(rx_byte);
                edited_items <= edited_items + 1;
            end
            mismatch_count <= mismatch_count + bad;
            results_outstanding <= expected_bytes.size();
        end
    end

endmodule

// File: sim/tb_filtered_line_editor_core.sv
`timescale 1ns / 1ps
// Testbench top for filtered_line_editor_core: clock, reset, register writes, byte
// requests and output back-pressure; depends on fle_pkg and filtered_line_editor_checker.
module tb_filtered_line_editor_core;

    localparam logic [2:0] MODE_ADDR    = {fle_pkg::REG_CHAR_CLASS_MODE, 2'b00};
    localparam logic [2:0] LENGTH_ADDR  = {fle_pkg::REG_MAX_LENGTH, 2'b00};
    localparam int         TARGET_ITEMS = 330;
    localparam int         CALM_FROM    = 290;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         SETTLE       = 6;
    localparam int         CYCLE_LIMIT  = 1000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        is_echo;
    logic        last;

    int mismatch_count;
    int results_outstanding;
    int edited_items;
    int cycles;
    bit calm;
    bit long_hold;

    filtered_line_editor_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .is_echo   (is_echo),
        .last      (last)
    );

    filtered_line_editor_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .out_byte            (out_byte),
        .is_echo             (is_echo),
        .last                (last),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding),
        .edited_items        (edited_items)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** filtered_line_editor_core: FAILED **");
        $finish;
    end

    // output back-pressure: random ready runs and stalls, one long hold on request
    initial
    begin
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_line_config(input logic [1:0] mode, input logic [5:0] max_len);
        reg_write(MODE_ADDR, {30'd0, mode});
        reg_write(LENGTH_ADDR, {26'd0, max_len});
    endtask

    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop the request, hold until every result is out, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [7:0] class_char(input logic [1:0] mode);
        logic [7:0] punct[5];
        int pick;
        punct[0] = fle_pkg::CHAR_SPACE;
        punct[1] = fle_pkg::CHAR_BANG;
        punct[2] = fle_pkg::CHAR_DOT;
        punct[3] = fle_pkg::CHAR_MINUS;
        punct[4] = fle_pkg::CHAR_PLUS;
        pick = $urandom_range(0, 9);
        if (mode == fle_pkg::MODE_DIGITS ||
            (mode != fle_pkg::MODE_LETTERS && pick >= 6 && pick < 8))
            return 8'h30 + 8'($urandom_range(0, 9));
        if (mode == fle_pkg::MODE_LETTERS || pick < 6)
            return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
        return punct[$urandom_range(0, 4)];
    endfunction

    function automatic logic [7:0] next_byte(input logic [1:0] mode);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return class_char(mode);
        if (pick < 80)
            return $urandom_range(0, 1) ? fle_pkg::CHAR_BS : fle_pkg::CHAR_DEL;
        if (pick < 88)
            return $urandom_range(0, 1) ? fle_pkg::CHAR_CR : fle_pkg::CHAR_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [5:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd63;
            3:       return 6'd32;
            default: return 6'($urandom_range(2, 10));
        endcase
    endfunction

    initial
    begin
        int phase;
        int count;
        logic [1:0] mode;
        logic [5:0] max_len;

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        rx_byte  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte("A");
        send_byte("z");
        send_byte("0");
        send_byte("9");
        send_byte(fle_pkg::CHAR_SPACE);
        send_byte(fle_pkg::CHAR_BANG);
        send_byte(fle_pkg::CHAR_DOT);
        send_byte(fle_pkg::CHAR_MINUS);
        send_byte(fle_pkg::CHAR_PLUS);
        send_byte(fle_pkg::CHAR_DEL);
        send_byte(fle_pkg::CHAR_BS);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte("#");
        send_byte(fle_pkg::CHAR_CR);
        send_byte(fle_pkg::CHAR_BS);
        send_byte(fle_pkg::CHAR_LF);
        send_byte("a");
        send_byte("b");
        send_byte("c");
        send_byte("d");
        wait_idle();
        set_line_config(fle_pkg::MODE_TEXT, 6'd3);
        send_byte("e");
        wait_idle();
        set_line_config(fle_pkg::MODE_DIGITS, 6'd0);
        send_byte("7");
        send_byte("x");
        wait_idle();
        set_line_config(fle_pkg::MODE_LETTERS, 6'd63);
        send_byte("Q");
        send_byte("5");
        send_byte(fle_pkg::CHAR_CR);

        phase = 0;
        while (edited_items < TARGET_ITEMS)
        begin
            calm = (edited_items >= CALM_FROM);
            wait_idle();
            mode    = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            max_len = (phase == 0) ? 6'd63 : pick_length();
            set_line_config(mode, max_len);
            if (phase == 0)
            begin
                repeat (fle_pkg::DEFAULT_BUFFER_DEPTH - 1) send_byte(class_char(mode));
            end
            else
            begin
                if (phase == 2)
                    long_hold = 1'b1;
                count = $urandom_range(15, 35);
                for (int i = 0; i < count; i++)
                begin
                    if (phase == 4 && i == count / 2)
                        wait_idle();
                    send_byte(next_byte(mode));
                end
            end
            phase++;
        end
        calm = 1'b1;
        wait_idle();

        if (mismatch_count == 0)
            $display("** filtered_line_editor_core: PASSED **");
        else
            $display("** filtered_line_editor_core: FAILED **");
        $finish;
    end

endmodule
